// ===== hw/rtl/cbeq_pkg.sv =====
// Shared constants and types for the cascaded biquad equalizer.
// No dependencies; imported by the top level.
package cbeq_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int NUM_BANDS_DEF    = 6;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int COEF_BITS_DEF    = 32;

  // Fixed formats
  localparam int MASK_BITS     = 6;   // width of the band enable register
  localparam int NUM_COEFS     = 5;   // b0 b1 b2 a1 a2
  localparam int GUARD_BITS    = 9;   // delay scale above sample scale
  localparam int COEF_INT_BITS = 6;   // Q5.26 integer part incl. sign
  localparam int DELAY_EXTRA   = 16;  // delay word is sample width plus this

  localparam logic [MASK_BITS-1:0] MASK_RESET = 6'd63;

  // Coefficient selectors
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_COEF_WRITE = 1'b1
  } op_t;

endpackage

// ===== hw/rtl/cbeq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cascaded_biquad_equalizer_top.sv =====
// Cascaded biquad equalizer, DF2T sections sharing one multiplier; top level.
// Depends on cbeq_pkg and cbeq_ram.
//
// Sequence: each enabled band runs the full step sequence and each bypassed band
//   only its address step; then the result register loads.
// A new sample item is taken only when idle, once the last result has gone into the
//   result register; the five products per band share the single multiplier.
// A coefficient-write item is taken while idle and gives no result.
// Reset (rst, synchronous): enable mask all ones, every coefficient reads as unity
//   (b0 = 1.0, rest 0) and every delay as zero, via valid bits; no clearing pass.
module cascaded_biquad_equalizer_top
  import cbeq_pkg::*;
#(
  parameter int NUM_BANDS    = NUM_BANDS_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: band enable mask
  input  logic                          cfg_we,
  input  logic [MASK_BITS-1:0]          cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic                          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [2:0]                    band,
  input  logic [2:0]                    coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_channel,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int DB     = SAMPLE_BITS + DELAY_EXTRA;              // delay word
  localparam int PW     = SAMPLE_BITS + COEF_BITS;                // raw product
  localparam int PS     = COEF_BITS - COEF_INT_BITS - GUARD_BITS; // product shift
  localparam int SW     = PW - PS;                                // scaled product
  localparam int AW     = DB + 2;                                 // z accumulators
  localparam int ACC0W  = DB + 1;                                 // band output sum
  localparam int YW     = ACC0W - GUARD_BITS;                     // y before sat
  localparam int CDEPTH = NUM_BANDS * NUM_COEFS;
  localparam int DDEPTH = NUM_BANDS * NUM_CHANNELS;
  localparam int CAW    = CDEPTH > 1 ? $clog2(CDEPTH) : 1;
  localparam int DAW    = DDEPTH > 1 ? $clog2(DDEPTH) : 1;
  localparam int BIW    = NUM_BANDS > 1 ? $clog2(NUM_BANDS) : 1;
  localparam int CHW    = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    COEF_BITS'(1) << (COEF_BITS - COEF_INT_BITS);
  localparam logic signed [PW-1:0]    PROD_HALF = PW'(1) << (PS - 1);
  localparam logic signed [ACC0W-1:0] Y_ROUND   = ACC0W'(1) << (GUARD_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [DB-1:0]    D_MAX = {1'b0, {(DB-1){1'b1}}};
  localparam logic signed [DB-1:0]    D_MIN = {1'b1, {(DB-1){1'b0}}};
  localparam logic [BIW-1:0]          LAST_BAND = BIW'(NUM_BANDS - 1);

  // Per-band sequence. Step k also issues the read of coefficient k.
  localparam logic [2:0] STEP_ADDR = 3'd0;  // read delay row, coef b0
  localparam logic [2:0] STEP_MB0  = 3'd1;  // x*b0, latch z1/z2
  localparam logic [2:0] STEP_MB1  = 3'd2;  // x*b1, form y
  localparam logic [2:0] STEP_MB2  = 3'd3;  // x*b2, acc1 = x*b1
  localparam logic [2:0] STEP_MA1  = 3'd4;  // y*a1, acc2 = x*b2
  localparam logic [2:0] STEP_MA2  = 3'd5;  // y*a2, acc1 -= y*a1, += z2
  localparam logic [2:0] STEP_WB   = 3'd6;  // write z1/z2 back

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                   state;
  logic [2:0]               step;
  logic [BIW-1:0]           band_idx;
  logic [CHW-1:0]           ch_q;
  logic [MASK_BITS-1:0]     mask_q;
  logic [CDEPTH-1:0]        coef_vld;   // entry written since reset
  logic [DDEPTH-1:0]        dly_vld;    // row written since reset/clear
  logic                     coef_vld_q; // valid of the entry being read out
  logic                     coef_b0_q;  // entry being read out is a b0
  logic                     dly_vld_q;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic                          clip_q;
  logic signed [DB-1:0]          z1_q;
  logic signed [DB-1:0]          z2_q;
  logic signed [AW-1:0]          acc1_q;
  logic signed [AW-1:0]          acc2_q;
  logic signed [PW-1:0]          prod_q;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                   coef_we;
  logic [CAW-1:0]         coef_waddr;
  logic [CAW-1:0]         coef_raddr;
  logic [COEF_BITS-1:0]   coef_rdata;
  logic                   dly_we;
  logic [DAW-1:0]         dly_addr;
  logic [2*DB-1:0]        dly_wdata;
  logic [2*DB-1:0]        dly_rdata;

  cbeq_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  cbeq_ram #(
    .WIDTH (2 * DB),
    .DEPTH (DDEPTH)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_addr),
    .wdata (dly_wdata),
    .raddr (dly_addr),
    .rdata (dly_rdata)
  );

  // ---------------------------------------------------------------------------
  // Combinational datapath
  // ---------------------------------------------------------------------------
  logic                     in_acc;
  logic                     coef_wr_ok;
  logic                     out_load;
  logic [NUM_BANDS-1:0]     band_on_vec;
  logic                     band_on;
  logic signed [COEF_BITS-1:0]   coef_eff;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW-1:0]          prod_rnd;
  logic signed [SW-1:0]          prod_sc;
  logic signed [ACC0W-1:0]       acc0;
  logic signed [YW-1:0]          y_pre;
  logic                          y_ovf;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [AW-1:0]          z2_full;

  function automatic logic signed [DB-1:0] sat_delay(input logic signed [AW-1:0] v);
    logic ovf;
    ovf = (v[AW-1:DB-1] != {(AW-DB+1){v[AW-1]}});
    if (ovf) begin
      return v[AW-1] ? D_MIN : D_MAX;
    end
    return v[DB-1:0];
  endfunction

  // bands past the mask register width are always on
  for (genvar i = 0; i < NUM_BANDS; i++) begin : g_band_on
    if (i < MASK_BITS) begin : g_mask
      assign band_on_vec[i] = mask_q[i];
    end else begin : g_fixed
      assign band_on_vec[i] = 1'b1;
    end
  end
  assign band_on = band_on_vec[band_idx];

  assign in_ready   = (state == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign coef_wr_ok = (int'(band) < NUM_BANDS) && (coef_index <= COEF_A2);
  assign coef_we    = in_acc && (operation == OP_COEF_WRITE) && coef_wr_ok;
  assign coef_waddr = CAW'(int'(band) * NUM_COEFS + int'(coef_index));
  assign coef_raddr = CAW'(int'(band_idx) * NUM_COEFS + int'(step));
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  assign dly_addr  = DAW'(int'(band_idx) * NUM_CHANNELS + int'(ch_q));
  assign dly_we    = (state == S_RUN) && (step == STEP_WB);

  // unwritten coefficient reads as unity section
  assign coef_eff = coef_vld_q ? coef_rdata : (coef_b0_q ? COEF_ONE : '0);
  assign mul_a    = (step <= STEP_MB2) ? x_q : y_q;
  assign mul_p    = PW'(mul_a) * PW'(coef_eff);

  // round half up, then drop PS bits
  assign prod_rnd = prod_q + PROD_HALF;
  assign prod_sc  = prod_rnd[PW-1:PS];

  assign acc0  = ACC0W'(prod_sc) + ACC0W'(z1_q) + Y_ROUND;
  assign y_pre = acc0[ACC0W-1:GUARD_BITS];
  assign y_ovf = (y_pre[YW-1:SAMPLE_BITS-1] != {(YW-SAMPLE_BITS+1){y_pre[YW-1]}});
  assign y_sat = y_ovf ? (y_pre[YW-1] ? S_MIN : S_MAX) : y_pre[SAMPLE_BITS-1:0];

  assign z2_full   = acc2_q - AW'(prod_sc);
  assign dly_wdata = {sat_delay(acc1_q), sat_delay(z2_full)};

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_ADDR;
      band_idx  <= '0;
      mask_q    <= MASK_RESET;
      coef_vld  <= '0;
      dly_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_q <= cfg_data;
      end
      // load wins over drain; a taken result with nothing behind it empties
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
        // new coefficient: every channel of that band restarts from zero
        for (int r = 0; r < DDEPTH; r++) begin
          if (r / NUM_CHANNELS == int'(band)) begin
            dly_vld[r] <= 1'b0;
          end
        end
      end
      if (dly_we) begin
        dly_vld[dly_addr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && operation == OP_SAMPLE) begin
            state    <= S_RUN;
            step     <= STEP_ADDR;
            band_idx <= '0;
          end
        end
        S_RUN: begin
          if ((step == STEP_ADDR && !band_on) || step == STEP_WB) begin
            step <= STEP_ADDR;
            if (band_idx == LAST_BAND) begin
              state <= S_DONE;
            end else begin
              band_idx <= band_idx + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    coef_vld_q <= coef_vld[coef_raddr];
    coef_b0_q  <= (step == STEP_ADDR);
    dly_vld_q  <= dly_vld[dly_addr];
    prod_q     <= mul_p;

    if (in_acc && operation == OP_SAMPLE) begin
      x_q    <= sample_in;
      ch_q   <= (NUM_CHANNELS > 1) ? CHW'(channel) : '0;
      clip_q <= 1'b0;
    end

    if (state == S_RUN) begin
      unique case (step)
        STEP_MB0: begin
          z1_q <= dly_vld_q ? dly_rdata[2*DB-1:DB] : '0;
          z2_q <= dly_vld_q ? dly_rdata[DB-1:0]    : '0;
        end
        STEP_MB1: begin
          y_q    <= y_sat;
          clip_q <= clip_q | y_ovf;
        end
        STEP_MB2: acc1_q <= AW'(prod_sc);
        STEP_MA1: acc2_q <= AW'(prod_sc);
        STEP_MA2: acc1_q <= acc1_q - AW'(prod_sc) + AW'(z2_q);
        STEP_WB:  x_q    <= y_q;
        default: ;
      endcase
    end

    if (out_load) begin
      out_channel <= ch_q[0];
      sample_out  <= x_q;
      clipped     <= clip_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // delay write-back always follows the address step that read its row
  a_wb_after_read: assert property (@(posedge clk) disable iff (rst)
    dly_we |-> $past(state == S_RUN && step == STEP_ADDR, 6))
    else $error("delay write-back without matching read");

  a_coef_wr_idle: assert property (@(posedge clk) disable iff (rst)
    coef_we |-> state == S_IDLE)
    else $error("coefficient write during a sample");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step <= STEP_WB)
    else $error("band step counter out of range");

  a_sample_start: assert property (@(posedge clk) disable iff (rst)
    in_acc && operation == OP_SAMPLE |=> state == S_RUN && band_idx == '0 && step == STEP_ADDR)
    else $error("sample item did not start at band zero");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || out_ready) |=> out_valid && state == S_IDLE)
    else $error("finished sample not moved to output register");

endmodule
